### rtl/core/arpc_pkg.sv
// Package: shared types and constants for the ARP cache table
`default_nettype none
package arpc_pkg;
  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned AGE_W = 16;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned IDX_W = 3;

  localparam logic [IP_W-1:0]  IP_ONES  = '1;
  localparam logic [MAC_W-1:0] MAC_ONES = '1;
  localparam logic [15:0]      ARP_REQUEST = 16'd1;
  localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd300;

  typedef enum logic [OP_W-1:0] {
    OP_ATTACH = 3'd0,
    OP_UPDATE = 3'd1,
    OP_QUERY  = 3'd2,
    OP_TICK   = 3'd3,
    OP_SEND   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEND,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] slot;
    logic [IP_W-1:0]  own_addr;
    logic [MAC_W-1:0] own_hw;
    logic [IP_W-1:0]  peer_ip;
    logic [MAC_W-1:0] peer_hw;
    logic [15:0]      arp_op;
    logic             broadcast;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic             status;
    logic [MAC_W-1:0] found_mac;
    logic             removed;
    logic [15:0]      frame_opcode;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [MAC_W-1:0] target_mac;
    logic [IP_W-1:0]  target_ip;
    logic [IDX_W-1:0] device;
    logic             last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic exec;      // run attach/update/query/tick, build status
    logic send_emit; // emit frame for current send slot
    logic send_stat; // build final send status
    logic out_load;  // output register takes built result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_send;
    logic sel_any;   // some selected slot remains
  } sts_t;
endpackage
`default_nettype wire

### rtl/core/arpc_if.sv
// Interface: valid/ready channel carrying one payload
`default_nettype none
interface arpc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/arp_cache_table_top.sv
// Top level: ARP cache table with per-interface slots
//
//  channel  dir  payload              transfer when
//  req      in   arpc_pkg::req_t      req.valid & req.ready
//  rsp      out  arpc_pkg::rsp_t      rsp.valid & rsp.ready
//  cfg      in   max_age (16 bit)     cfg.valid & cfg.ready
//
// attach/update/query/tick: capture, then execute.
// send: capture, select, one frame per selected slot (one per cycle while the
// output is free) from a priority pick over a pending mask, end check, final
// status. A stalled output holds the controller in place; no new request is
// taken until the final status is registered.
// rst is synchronous; max_age resets to 300, all slots invalid.
`default_nettype none
module arp_cache_table_top #(
  parameter int unsigned SLOTS = 8
) (
  input wire logic clk,
  input wire logic rst,
  arpc_if.sink     req,
  arpc_if.source   rsp,
  arpc_if.sink     cfg
);
  import arpc_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] max_age;
  req_t        req_data;
  rsp_t        rsp_data;
  logic [15:0] cfg_data;

  assign req_data  = req.data;
  assign cfg_data  = cfg.data;
  assign rsp.data  = rsp_data;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) max_age <= MAX_AGE_RESET;
    else if (cfg.valid) max_age <= cfg_data;
  end

  arpc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts(sts), .cmd(cmd)
  );

  arpc_dp #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req_in(req_data),
    .max_age(max_age), .sts(sts), .rsp(rsp_data)
  );
endmodule
`default_nettype wire

### rtl/core/arpc_ctrl.sv
// Controller: sequences one request and its results
`default_nettype none
module arpc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire arpc_pkg::sts_t sts,
  output arpc_pkg::cmd_t      cmd
);
  import arpc_pkg::*;

  state_t state, state_next;
  logic   out_full, out_full_next;
  logic   out_free;

  assign out_free  = !out_full || out_ready;
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (sts.is_send) state_next = ST_SEND;
        else if (out_free) state_next = ST_IDLE;
      end
      ST_SEND: if (out_free && !sts.sel_any) state_next = ST_STATUS;
      ST_STATUS: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec     = out_free && !sts.is_send;
        cmd.out_load = out_free && !sts.is_send;
      end
      ST_SEND: begin
        cmd.send_emit = out_free && sts.sel_any;
        cmd.out_load  = out_free && sts.sel_any;
      end
      ST_STATUS: begin
        cmd.send_stat = out_free;
        cmd.out_load  = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (out_ready) out_full_next = 1'b0;
    if (cmd.out_load) out_full_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_ready) |=> out_full) else $error("result dropped");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free) else $error("result overwritten");
endmodule
`default_nettype wire

### rtl/core/arpc_dp.sv
// Datapath: slot table, matching, ageing and result register
`default_nettype none
module arpc_dp #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire arpc_pkg::cmd_t  cmd,
  input  wire arpc_pkg::req_t  req_in,
  input  wire logic [15:0]     max_age,
  output arpc_pkg::sts_t       sts,
  output arpc_pkg::rsp_t       rsp
);
  import arpc_pkg::*;

  req_t             req;
  logic [SLOTS-1:0] slot_valid;
  logic [SLOTS-1:0] never_ages;
  logic [IP_W-1:0]  own_ip [SLOTS];
  logic [MAC_W-1:0] own_mac [SLOTS];
  logic [IP_W-1:0]  nb_ip [SLOTS];
  logic [MAC_W-1:0] nb_mac [SLOTS];
  logic [AGE_W-1:0] age_left [SLOTS];
  logic [SLOTS-1:0] pending;  // slots still to send
  logic [SLOTS-1:0] pending_next;

  logic [SLOTS-1:0] upd_hit, qry_hit, sel, upd_first;
  logic [IDX_W-1:0] qry_idx, snd_idx;
  logic             bcast;
  logic             slot_ok;
  rsp_t             built;

  assign bcast   = req.broadcast || (req.peer_ip == IP_ONES);
  assign slot_ok = {1'b0, req.slot} < (IDX_W+1)'(SLOTS);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      upd_hit[i] = slot_valid[i] && (own_ip[i] == req.own_addr);
      qry_hit[i] = slot_valid[i] && (nb_ip[i] == req.peer_ip);
      sel[i]     = slot_valid[i] && (bcast || nb_ip[i] == req.peer_ip);
    end
  end

  always_comb begin
    upd_first = '0;
    qry_idx   = '0;
    for (int i = SLOTS-1; i >= 0; i--) begin
      if (qry_hit[i]) qry_idx = IDX_W'(i);
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (upd_hit[i] && (upd_first == '0)) upd_first[i] = 1'b1;
    end
    snd_idx = '0;
    for (int i = SLOTS-1; i >= 0; i--) begin
      if (pending[i]) snd_idx = IDX_W'(i);
    end
  end

  assign sts.is_send = (req.op == OP_SEND);
  assign sts.sel_any = |pending;

  always_comb begin
    built = '0;
    built.last = 1'b1;
    if (cmd.send_emit) begin
      built.last         = 1'b0;
      built.kind         = 1'b1;
      built.frame_opcode = req.arp_op;
      built.sender_mac   = own_mac[snd_idx];
      built.sender_ip    = own_ip[snd_idx];
      built.target_mac   = (req.arp_op == ARP_REQUEST) ? MAC_ONES : nb_mac[snd_idx];
      built.target_ip    = nb_ip[snd_idx];
      built.device       = snd_idx;
    end else if (!cmd.send_stat) begin
      case (req.op)
        OP_ATTACH: built.status = !slot_ok;
        OP_UPDATE: built.status = !(|upd_hit);
        OP_QUERY: begin
          built.status    = !(|qry_hit);
          built.found_mac = (|qry_hit) ? nb_mac[qry_idx] : '0;
        end
        OP_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && !never_ages[i] && age_left[i] == '0) built.removed = 1'b1;
          end
        end
        default: built.status = 1'b1;
      endcase
    end
  end

  // a send request marks all slots, then the select cycle narrows to sel
  always_comb begin
    pending_next = pending;
    if (cmd.load) begin
      pending_next = (req_in.op == OP_SEND) ? '1 : '0;
    end else if (cmd.send_emit) begin
      pending_next[snd_idx] = 1'b0;
    end else if (req.op == OP_SEND && pending == '1) begin
      pending_next = sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req <= req_in;
    if (cmd.out_load) rsp <= built;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      pending    <= '0;
    end else begin
      pending <= pending_next;
      if (cmd.exec) begin
        case (req.op)
          OP_ATTACH: if (slot_ok) slot_valid[req.slot] <= 1'b1;
          OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_valid[i] && !never_ages[i] && age_left[i] == '0)
                slot_valid[i] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (req.op)
        OP_ATTACH: if (slot_ok) begin
          own_ip[req.slot]     <= req.own_addr;
          own_mac[req.slot]    <= req.own_hw;
          nb_ip[req.slot]      <= IP_ONES;
          nb_mac[req.slot]     <= MAC_ONES;
          age_left[req.slot]   <= '0;
          never_ages[req.slot] <= 1'b1;
        end
        OP_UPDATE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (upd_first[i]) begin
              nb_ip[i]      <= req.peer_ip;
              nb_mac[i]     <= req.peer_hw;
              age_left[i]   <= max_age;
              never_ages[i] <= 1'b0;
            end
          end
        end
        OP_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && !never_ages[i] && age_left[i] != '0)
              age_left[i] <= age_left[i] - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_emit_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.send_emit |-> pending[snd_idx]) else $error("emit without pending slot");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.send_emit |=> !pending[$past(snd_idx)]) else $error("slot sent twice");
  a_valid_attach: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && req.op == OP_ATTACH && slot_ok) |=> slot_valid[$past(req.slot)])
    else $error("attach lost");
endmodule
`default_nettype wire

### verif/arpc_tb_if.sv
// Testbench package: shared constants for the ARP cache table testbench
package arpc_tb_pkg;
  import arpc_pkg::*;
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;
endpackage

### verif/tb.sv
// ARP cache table testbench: directed and random requests vs a slot table predictor
module tb;
  import arpc_pkg::*;
  import arpc_tb_pkg::*;

  localparam int NSLOT = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  arpc_if #(.T(req_t))        req_ch ();
  arpc_if #(.T(rsp_t))        rsp_ch ();
  arpc_if #(.T(logic [15:0])) cfg_ch ();

  arp_cache_table_top #(.SLOTS(NSLOT)) i_dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // table mirror
  logic [15:0] age_limit;
  logic        t_valid [NSLOT];
  logic [31:0] t_lip   [NSLOT];
  logic [47:0] t_lmac  [NSLOT];
  logic [31:0] t_pip   [NSLOT];
  logic [47:0] t_pmac  [NSLOT];
  logic [15:0] t_age   [NSLOT];
  logic        t_fixed [NSLOT];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  bit   calm = 1'b0;
  bit   req_fired = 1'b0;
  int   req_gap = 0, rsp_gap = 0;

  function automatic rsp_t status_rsp(logic st, logic [47:0] mac, logic rem);
    rsp_t r;
    r = '0;
    r.status = st; r.found_mac = mac; r.removed = rem; r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_table(input req_t q);
    rsp_t r;
    logic hit, rem, bc;
    hit = 1'b0; rem = 1'b0;
    case (q.op)
      OP_ATTACH: begin
        t_valid[q.slot] = 1'b1; t_lip[q.slot] = q.own_addr; t_lmac[q.slot] = q.own_hw;
        t_pip[q.slot] = IP_ONES; t_pmac[q.slot] = MAC_ONES; t_age[q.slot] = '0;
        t_fixed[q.slot] = 1'b1;
        expected_rsps = {expected_rsps, status_rsp(1'b0, '0, 1'b0)};
      end
      OP_UPDATE: begin
        for (int i = 0; i < NSLOT; i++)
          if (!hit && t_valid[i] && t_lip[i] == q.own_addr) begin
            hit = 1'b1; t_pip[i] = q.peer_ip; t_pmac[i] = q.peer_hw;
            t_age[i] = age_limit; t_fixed[i] = 1'b0;
          end
        expected_rsps = {expected_rsps, status_rsp(!hit, '0, 1'b0)};
      end
      OP_QUERY: begin
        r = status_rsp(1'b1, '0, 1'b0);
        for (int i = 0; i < NSLOT; i++)
          if (!hit && t_valid[i] && t_pip[i] == q.peer_ip) begin
            hit = 1'b1; r = status_rsp(1'b0, t_pmac[i], 1'b0);
          end
        expected_rsps = {expected_rsps, r};
      end
      OP_TICK: begin
        for (int i = 0; i < NSLOT; i++)
          if (t_valid[i] && !t_fixed[i]) begin
            if (t_age[i] != 0) t_age[i] = t_age[i] - 16'd1;
            else begin
              t_valid[i] = 1'b0; rem = 1'b1;
            end
          end
        expected_rsps = {expected_rsps, status_rsp(1'b0, '0, rem)};
      end
      OP_SEND: begin
        bc = q.broadcast || q.peer_ip == IP_ONES;
        for (int i = 0; i < NSLOT; i++)
          if (t_valid[i] && (bc || t_pip[i] == q.peer_ip)) begin
            r = '0;
            r.kind = 1'b1; r.frame_opcode = q.arp_op;
            r.sender_mac = t_lmac[i]; r.sender_ip = t_lip[i];
            r.target_mac = (q.arp_op == ARP_REQUEST) ? MAC_ONES : t_pmac[i];
            r.target_ip = t_pip[i]; r.device = i[2:0];
            expected_rsps = {expected_rsps, r};
          end
        expected_rsps = {expected_rsps, status_rsp(1'b0, '0, 1'b0)};
      end
      default: expected_rsps = {expected_rsps, status_rsp(1'b1, '0, 1'b0)};
    endcase
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_fired) begin
    end else begin
      req_fired = 1'b0;
      if (req_gap > 0) begin
        req_gap = req_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_ch.data  <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 16);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap = rsp_gap - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 6) == 0) rsp_gap = $urandom_range(1, 16);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      req_fired = 1'b1;
      predict_table(req_ch.data);
    end
    if (!rst && cfg_ch.valid && cfg_ch.ready) age_limit = cfg_ch.data;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected transfer on rsp");
        errors++;
      end else begin
        rsp_t e, a;
        e = expected_rsps.pop_front();
        a = rsp_ch.data;
        if (a.kind !== e.kind) begin
          $error("kind exp %0h got %0h", e.kind, a.kind); errors++;
        end
        if (a.status !== e.status) begin
          $error("status exp %0h got %0h", e.status, a.status); errors++;
        end
        if (a.found_mac !== e.found_mac) begin
          $error("found_mac exp %0h got %0h", e.found_mac, a.found_mac); errors++;
        end
        if (a.removed !== e.removed) begin
          $error("removed exp %0h got %0h", e.removed, a.removed); errors++;
        end
        if (a.frame_opcode !== e.frame_opcode) begin
          $error("frame_opcode exp %0h got %0h", e.frame_opcode, a.frame_opcode); errors++;
        end
        if (a.sender_mac !== e.sender_mac) begin
          $error("sender_mac exp %0h got %0h", e.sender_mac, a.sender_mac); errors++;
        end
        if (a.sender_ip !== e.sender_ip) begin
          $error("sender_ip exp %0h got %0h", e.sender_ip, a.sender_ip); errors++;
        end
        if (a.target_mac !== e.target_mac) begin
          $error("target_mac exp %0h got %0h", e.target_mac, a.target_mac); errors++;
        end
        if (a.target_ip !== e.target_ip) begin
          $error("target_ip exp %0h got %0h", e.target_ip, a.target_ip); errors++;
        end
        if (a.device !== e.device) begin
          $error("device exp %0h got %0h", e.device, a.device); errors++;
        end
        if (a.last !== e.last) begin
          $error("last exp %0h got %0h", e.last, a.last); errors++;
        end
      end
    end
  end

  // small pools so lookups hit often
  logic [31:0] lip_pool [4];
  logic [31:0] pip_pool [4];

  function automatic req_t rand_req(int unsigned opw);
    req_t q;
    q.op        = opw[2:0];
    q.slot      = 3'($urandom_range(0, 7));
    q.own_addr  = ($urandom_range(0, 7) == 0) ? $urandom : lip_pool[$urandom_range(0, 3)];
    q.own_hw    = 48'({$urandom, $urandom});
    q.peer_ip   = ($urandom_range(0, 7) == 0) ? $urandom : pip_pool[$urandom_range(0, 3)];
    q.peer_hw   = 48'({$urandom, $urandom});
    q.arp_op    = ($urandom_range(0, 1) == 1) ? ARP_REQUEST : 16'($urandom);
    q.broadcast = ($urandom_range(0, 4) == 0);
    return q;
  endfunction

  task automatic wait_idle();
    while (!(pending_reqs.size() == 0 && !req_ch.valid && expected_rsps.size() == 0))
      @(posedge clk);
  endtask

  task automatic drain_then_cfg(input logic [15:0] v);
    wait_idle();
    repeat (8) @(negedge clk);
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    req_t q;
    logic [15:0] ages [5];
    ages = '{16'd65535, 16'd1, 16'd0, 16'd3, 16'd300};
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    age_limit = MAX_AGE_RESET;
    for (int i = 0; i < NSLOT; i++) t_valid[i] = 1'b0;
    lip_pool = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
    pip_pool = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: misses on empty table, attaches, ops, bad ops
    q = rand_req(OP_QUERY);  pending_reqs = {pending_reqs, q};
    q = rand_req(OP_UPDATE); pending_reqs = {pending_reqs, q};
    q = rand_req(OP_SEND);   pending_reqs = {pending_reqs, q};
    q = rand_req(OP_TICK);   pending_reqs = {pending_reqs, q};
    for (int i = 0; i < NSLOT; i++) begin
      q = rand_req(OP_ATTACH); q.slot = i[2:0];
      q.own_addr = lip_pool[i % 4];
      q.own_hw = (i == 0) ? 48'h0 : (i == 1) ? MAC_ONES : q.own_hw;
      pending_reqs = {pending_reqs, q};
    end
    q = rand_req(OP_SEND); q.peer_ip = IP_ONES; q.broadcast = 1'b0; q.arp_op = 16'hFFFF;
    pending_reqs = {pending_reqs, q};
    q = rand_req(OP_UPDATE); q.own_addr = lip_pool[2]; q.peer_ip = 32'h0;
    q.peer_hw = MAC_ONES; pending_reqs = {pending_reqs, q};
    q = rand_req(OP_QUERY); q.peer_ip = 32'h0; pending_reqs = {pending_reqs, q};
    q = rand_req(OP_SEND); q.peer_ip = 32'h0; q.broadcast = 1'b0; q.arp_op = 16'h0;
    pending_reqs = {pending_reqs, q};
    q = rand_req(OP_TICK); pending_reqs = {pending_reqs, q};
    for (int u = OP_BAD_LO; u <= OP_BAD_HI; u++) begin
      q = rand_req(u); pending_reqs = {pending_reqs, q};
    end
    q = rand_req(OP_ATTACH); q.slot = 3'd2; pending_reqs = {pending_reqs, q};
    q = rand_req(OP_SEND); q.broadcast = 1'b1; q.arp_op = ARP_REQUEST;
    pending_reqs = {pending_reqs, q};

    // random phases across max_age settings
    for (int ph = 0; ph < 5; ph++) begin
      drain_then_cfg(ages[ph]);
      if (ph == 4) calm = 1'b1;
      for (int n = 0; n < 70; n++) begin
        int unsigned w;
        w = $urandom_range(0, 99);
        q = rand_req(w < 15 ? OP_ATTACH : w < 35 ? OP_UPDATE : w < 55 ? OP_QUERY :
                     w < 75 ? OP_TICK : w < 97 ? OP_SEND :
                     $urandom_range(OP_BAD_LO, OP_BAD_HI));
        pending_reqs = {pending_reqs, q};
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### sim.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_if.sv
rtl/core/arpc_ctrl.sv
rtl/core/arpc_dp.sv
rtl/core/arp_cache_table_top.sv
verif/arpc_tb_if.sv
verif/tb.sv
